[rtl/jbt_pkg.sv]
// jbt_pkg: shared types, token codes and character tables for the json byte tokenizer
// no dependencies; imported by every rtl module of the tokenizer
package jbt_pkg;

    // widths of the item fields
    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 4;
    localparam int LEN_W     = 17;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_CHAR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TOKEN_LEN = 2'd1;

    // configuration reset values
    localparam logic [BYTE_W-1:0] ESCAPE_CHAR_RST   = 8'd92;
    localparam logic [LEN_W-1:0]  MAX_TOKEN_LEN_RST = 17'd127999;

    // token kinds
    localparam logic [KIND_W-1:0] TK_TEXT   = 4'd0;
    localparam logic [KIND_W-1:0] TK_LBRACE = 4'd1;
    localparam logic [KIND_W-1:0] TK_RBRACE = 4'd2;
    localparam logic [KIND_W-1:0] TK_LBRACK = 4'd3;
    localparam logic [KIND_W-1:0] TK_RBRACK = 4'd4;
    localparam logic [KIND_W-1:0] TK_COMMA  = 4'd5;
    localparam logic [KIND_W-1:0] TK_COLON  = 4'd6;
    localparam logic [KIND_W-1:0] TK_DQSTR  = 4'd7;
    localparam logic [KIND_W-1:0] TK_SQSTR  = 4'd8;
    localparam logic [KIND_W-1:0] TK_VAR    = 4'd9;
    localparam logic [KIND_W-1:0] TK_NUM    = 4'd10;
    localparam logic [KIND_W-1:0] TK_TRUE   = 4'd11;
    localparam logic [KIND_W-1:0] TK_FALSE  = 4'd12;
    localparam logic [KIND_W-1:0] TK_NULL   = 4'd13;
    localparam logic [KIND_W-1:0] TK_EOF    = 4'd14;
    localparam logic [KIND_W-1:0] TK_ERR    = 4'd15;

    // number phases
    localparam logic [2:0] PH_SIGN = 3'd0;
    localparam logic [2:0] PH_INT  = 3'd1;
    localparam logic [2:0] PH_ZERO = 3'd2;
    localparam logic [2:0] PH_FRAC = 3'd3;
    localparam logic [2:0] PH_EXPM = 3'd4;
    localparam logic [2:0] PH_EXPD = 3'd5;

    // string kinds
    localparam logic [1:0] SK_DQUOTE = 2'd0;
    localparam logic [1:0] SK_SQUOTE = 2'd1;
    localparam logic [1:0] SK_QMARK  = 2'd2;

    // constant kinds
    localparam logic [1:0] CK_TRUE  = 2'd0;
    localparam logic [1:0] CK_FALSE = 2'd1;
    localparam logic [1:0] CK_NULL  = 2'd2;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_STR   = 2'd2,
        MODE_CONST = 2'd3
    } lex_mode_t;

    typedef struct packed {
        logic [BYTE_W-1:0] in_byte;
        logic              end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [BYTE_W-1:0] text_byte;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] escape_char;
        logic [LEN_W-1:0]  max_token_len;
    } cfg_t;

    // results of one input item, items[0] first
    typedef struct packed {
        logic [1:0]      cnt;
        out_item_t [1:0] items;
    } res_pair_t;

    // closing quote of each string kind
    function automatic logic [BYTE_W-1:0] quote_of(input logic [1:0] k);
        logic [BYTE_W-1:0] q;
        case (k)
            SK_SQUOTE: q = 8'h27;
            SK_QMARK:  q = 8'h3F;
            default:   q = 8'h22;
        endcase
        return q;
    endfunction

    // token kind closing each string kind
    function automatic logic [KIND_W-1:0] str_tok(input logic [1:0] k);
        logic [KIND_W-1:0] t;
        case (k)
            SK_SQUOTE: t = TK_SQSTR;
            SK_QMARK:  t = TK_VAR;
            default:   t = TK_DQSTR;
        endcase
        return t;
    endfunction

    // letters after the first one of true, false and null
    function automatic logic [BYTE_W-1:0] const_tail(input logic [1:0] k, input logic [1:0] i);
        logic [BYTE_W-1:0] c;
        case ({k, i})
            {CK_TRUE, 2'd0}:  c = "r";
            {CK_TRUE, 2'd1}:  c = "u";
            {CK_TRUE, 2'd2}:  c = "e";
            {CK_FALSE, 2'd0}: c = "a";
            {CK_FALSE, 2'd1}: c = "l";
            {CK_FALSE, 2'd2}: c = "s";
            {CK_FALSE, 2'd3}: c = "e";
            {CK_NULL, 2'd0}, {2'd3, 2'd0}: c = "u";
            {CK_NULL, 2'd1}, {2'd3, 2'd1}: c = "l";
            {CK_NULL, 2'd2}, {2'd3, 2'd2}: c = "l";
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [2:0] const_len(input logic [1:0] k);
        return (k == CK_FALSE) ? 3'd4 : 3'd3;
    endfunction

    function automatic logic [KIND_W-1:0] const_tok(input logic [1:0] k);
        logic [KIND_W-1:0] t;
        case (k)
            CK_TRUE:  t = TK_TRUE;
            CK_FALSE: t = TK_FALSE;
            default:  t = TK_NULL;
        endcase
        return t;
    endfunction

endpackage

[rtl/json_byte_tokenizer_unit.sv]
// Streaming JSON tokenizer: one byte per cycle in, up to two result items per byte out; input
// is taken while the result queue has room. An accepted item is held in the input register,
// the lexer puts its results into the result queue, and m_valid shows them from the queue.
// Throughput: one item per cycle while each item gives at most one result and m_ready is high;
// two-result items can fill the queue and stall input, as the port shows one result at a time.
// Reset: aresetn synchronous, active low; lexer idle, queue empty, registers at reset values.
module json_byte_tokenizer_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  jbt_pkg::in_item_t                    s_item,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output jbt_pkg::out_item_t                   m_item,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [jbt_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [jbt_pkg::LEN_W-1:0]            cfg_data
);
    import jbt_pkg::*;

    logic      in_valid_reg;
    in_item_t  in_item_reg;
    cfg_t      cfg_reg;
    res_pair_t res;
    logic      room;
    logic      advance;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.escape_char   <= ESCAPE_CHAR_RST;
            cfg_reg.max_token_len <= MAX_TOKEN_LEN_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_ESCAPE_CHAR:   cfg_reg.escape_char   <= cfg_data[BYTE_W-1:0];
                CFG_MAX_TOKEN_LEN: cfg_reg.max_token_len <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register, drained when the queue has room for two results
    assign advance = in_valid_reg && room;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // lexer
    jbt_lexer u_lexer (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_reg),
        .res     (res)
    );

    // result queue
    jbt_res_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (advance),
        .res     (res),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

endmodule

[rtl/jbt_lexer.sv]
// jbt_lexer: lexer state registers and the per-byte next-state and result logic
// depends on jbt_pkg
module jbt_lexer (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  jbt_pkg::in_item_t   item,
    input  jbt_pkg::cfg_t       cfg,
    output jbt_pkg::res_pair_t  res
);
    import jbt_pkg::*;

    typedef struct packed {
        lex_mode_t        mode;
        logic [2:0]       phase;
        logic [1:0]       skind;
        logic             esc;
        logic [1:0]       ckind;
        logic [2:0]       cidx;
        logic [LEN_W-1:0] len;
    } lex_state_t;

    lex_state_t state_reg;
    lex_state_t state_next;

    // append one result item
    function automatic void emit(inout res_pair_t rp, input logic [KIND_W-1:0] k,
                                 input logic [BYTE_W-1:0] b);
        if (rp.cnt < 2'd2) begin
            rp.items[rp.cnt[0]].token_kind = k;
            rp.items[rp.cnt[0]].text_byte  = b;
            rp.items[rp.cnt[0]].last       = 1'b0;
            rp.cnt = rp.cnt + 2'd1;
        end
    endfunction

    // back to idle between tokens; string and constant kinds are kept
    function automatic void go_idle(inout lex_state_t st);
        st.mode  = MODE_IDLE;
        st.phase = PH_SIGN;
        st.esc   = 1'b0;
        st.cidx  = 3'd0;
        st.len   = '0;
    endfunction

    // next state and results for the byte at hand
    always_comb begin
        logic [BYTE_W-1:0] b;
        logic              dig;
        logic              acc;
        logic [2:0]        newp;
        logic [2:0]        ni;
        logic              run_idle;
        logic              do_text;
        lex_state_t        st;
        res_pair_t         rp;

        b        = item.in_byte;
        dig      = (b >= "0") && (b <= "9");
        acc      = 1'b0;
        newp     = state_reg.phase;
        ni       = state_reg.cidx + 3'd1;
        run_idle = 1'b0;
        do_text  = 1'b0;
        st       = state_reg;
        rp       = '0;

        if (item.end_of_input) begin
            // close whatever token is pending, then end of text
            if (st.mode == MODE_NUM) begin
                emit(rp, (st.phase == PH_SIGN) ? TK_ERR : TK_NUM, 8'h00);
            end else if (st.mode != MODE_IDLE) begin
                emit(rp, TK_ERR, 8'h00);
            end
            emit(rp, TK_EOF, 8'h00);
            go_idle(st);
        end else begin
            case (st.mode)
                MODE_NUM: begin
                    if (st.phase == PH_SIGN) begin
                        if (dig) begin
                            st.phase = (b == "0") ? PH_ZERO : PH_INT;
                            do_text  = 1'b1;
                        end else begin
                            emit(rp, TK_ERR, 8'h00);
                            go_idle(st);
                        end
                    end else begin
                        // does the byte extend the number
                        if (st.phase == PH_INT && dig) begin
                            acc = 1'b1;
                        end else if (st.phase == PH_INT || st.phase == PH_ZERO) begin
                            if (b == ".") begin
                                acc = 1'b1; newp = PH_FRAC;
                            end else if (b == "e" || b == "E") begin
                                acc = 1'b1; newp = PH_EXPM;
                            end
                        end else if (st.phase == PH_FRAC) begin
                            if (dig) begin
                                acc = 1'b1;
                            end else if (b == "e" || b == "E") begin
                                acc = 1'b1; newp = PH_EXPM;
                            end
                        end else if (st.phase == PH_EXPM) begin
                            if (b == "+" || b == "-" || dig) begin
                                acc = 1'b1; newp = PH_EXPD;
                            end
                        end else begin
                            acc = dig;
                        end
                        if (acc) begin
                            st.phase = newp;
                            do_text  = 1'b1;
                        end else begin
                            // number closed, byte handled as in idle
                            emit(rp, TK_NUM, 8'h00);
                            go_idle(st);
                            run_idle = 1'b1;
                        end
                    end
                end
                MODE_STR: begin
                    if (st.esc) begin
                        st.esc  = 1'b0;
                        do_text = 1'b1;
                    end else if (b == quote_of(st.skind)) begin
                        emit(rp, str_tok(st.skind), 8'h00);
                        go_idle(st);
                    end else if (b == cfg.escape_char) begin
                        st.esc = 1'b1;
                    end else begin
                        do_text = 1'b1;
                    end
                end
                MODE_CONST: begin
                    if (st.cidx < const_len(st.ckind)
                        && b == const_tail(st.ckind, st.cidx[1:0])) begin
                        if (ni >= const_len(st.ckind)) begin
                            emit(rp, const_tok(st.ckind), 8'h00);
                            go_idle(st);
                        end else begin
                            st.cidx = ni;
                        end
                    end else begin
                        emit(rp, TK_ERR, 8'h00);
                        go_idle(st);
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase
        end

        // byte between tokens
        if (run_idle) begin
            case (b)
                " ", 8'h0A, 8'h0C, 8'h09: begin
                end
                "{": emit(rp, TK_LBRACE, 8'h00);
                "}": emit(rp, TK_RBRACE, 8'h00);
                "[": emit(rp, TK_LBRACK, 8'h00);
                "]": emit(rp, TK_RBRACK, 8'h00);
                ",": emit(rp, TK_COMMA, 8'h00);
                ":": emit(rp, TK_COLON, 8'h00);
                8'h22, 8'h27, "?": begin
                    st.mode  = MODE_STR;
                    st.skind = (b == 8'h22) ? SK_DQUOTE : (b == 8'h27) ? SK_SQUOTE : SK_QMARK;
                    st.esc   = 1'b0;
                    st.len   = '0;
                end
                "t", "f", "n": begin
                    st.mode  = MODE_CONST;
                    st.ckind = (b == "t") ? CK_TRUE : (b == "f") ? CK_FALSE : CK_NULL;
                    st.cidx  = 3'd0;
                end
                "-", "0", "1", "2", "3", "4", "5", "6", "7", "8", "9": begin
                    st.mode  = MODE_NUM;
                    st.len   = '0;
                    st.phase = (b == "-") ? PH_SIGN : (b == "0") ? PH_ZERO : PH_INT;
                    do_text  = 1'b1;
                end
                default: emit(rp, TK_EOF, 8'h00);
            endcase
        end

        // text byte, or error when the token grows too long
        if (do_text) begin
            if (st.len >= cfg.max_token_len) begin
                emit(rp, TK_ERR, 8'h00);
                go_idle(st);
            end else begin
                st.len = LEN_W'(st.len + 1'b1);
                emit(rp, TK_TEXT, b);
            end
        end

        // mark the final result of this item
        if (rp.cnt != 2'd0) begin
            rp.items[rp.cnt[1]].last = 1'b1;
        end

        state_next = st;
        res        = rp;
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_IDLE, default: '0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/jbt_res_queue.sv]
// jbt_res_queue: four-entry result queue taking up to two items per cycle
// depends on jbt_pkg
module jbt_res_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  jbt_pkg::res_pair_t  res,
    output logic                room,
    output logic                m_valid,
    input  logic                m_ready,
    output jbt_pkg::out_item_t  m_item
);
    import jbt_pkg::*;

    out_item_t  entry_reg [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] wr_ptr_next;
    logic [1:0] rd_ptr_reg;
    logic [1:0] rd_ptr_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [1:0] push_cnt;
    logic       pop;

    // pointer and fill bookkeeping
    always_comb begin
        push_cnt    = push ? res.cnt : 2'd0;
        pop         = m_valid && m_ready;
        wr_ptr_next = wr_ptr_reg + push_cnt;
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + {1'b0, push_cnt} - {2'b00, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry writes
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            entry_reg[wr_ptr_reg] <= res.items[0];
        end
        if (push_cnt == 2'd2) begin
            entry_reg[wr_ptr_reg + 2'd1] <= res.items[1];
        end
    end

    // two free entries needed for the next item
    assign room    = (count_reg <= 3'd2);
    assign m_valid = (count_reg != 3'd0);
    assign m_item  = entry_reg[rd_ptr_reg];

endmodule

[rtl/jbt_checker.sv]
// jbt_checker: port-level assertions for the json byte tokenizer, bound to the top level
// depends on jbt_pkg and json_byte_tokenizer_unit
module jbt_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input jbt_pkg::in_item_t                 s_item,
    input logic                              m_valid,
    input logic                              m_ready,
    input jbt_pkg::out_item_t                m_item,
    input logic                              cfg_valid,
    input logic                              cfg_ready,
    input logic [jbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input logic [jbt_pkg::LEN_W-1:0]         cfg_data
);
    import jbt_pkg::*;

    // no result shows right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    // a text byte always ends its item's results
    a_text_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.token_kind == TK_TEXT |-> m_item.last)
        else $error("text byte not marked last");

    // only a number or error token can be followed by a second result
    a_first_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.last |-> m_item.token_kind == TK_NUM || m_item.token_kind == TK_ERR)
        else $error("unexpected first of two results");

    // the second result of an item is already queued
    a_second_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_item.last |=> m_valid)
        else $error("second result of an item missing");

endmodule

bind json_byte_tokenizer_unit jbt_checker u_jbt_checker (.*);
